>>> src/vbm_pkg.sv
// Shared types and constants for the Voronoi blend mask pixel block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vbm_pkg;

  localparam int COORD_W    = 20;
  localparam int SIZE_W     = 16;
  localparam int PIX_W      = 16;
  localparam int MTILES_W   = 16;
  localparam int TIDX_W     = 4;
  localparam int MVAL_W     = 8;
  localparam int MARGIN_W   = 20;
  localparam int TCOUNT_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [MVAL_W-1:0] MVAL_MAX = 8'd255;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_PIXEL = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MARGIN     = 1'b0,
    CFG_TILE_COUNT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic        [SIZE_W-1:0]  w;
    logic        [SIZE_W-1:0]  h;
  } tile_rec_t;

  localparam int TILE_REC_W = $bits(tile_rec_t);

endpackage

`default_nettype wire

>>> src/vbm_if.sv
// Valid/ready channel interfaces for pixel/load items and mask results.
// Depends on vbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface vbm_in_if;
  import vbm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [TIDX_W-1:0]          tile_index;
  logic signed [COORD_W-1:0]  origin_x;
  logic signed [COORD_W-1:0]  origin_y;
  logic [SIZE_W-1:0]          tile_width;
  logic [SIZE_W-1:0]          tile_height;
  logic [PIX_W-1:0]           pixel_x;
  logic [PIX_W-1:0]           pixel_y;
  logic [MTILES_W-1:0]        masked_tiles;

  modport source (output valid, func, tile_index, origin_x, origin_y, tile_width,
                  tile_height, pixel_x, pixel_y, masked_tiles, input ready);
  modport sink   (input valid, func, tile_index, origin_x, origin_y, tile_width,
                  tile_height, pixel_x, pixel_y, masked_tiles, output ready);
endinterface

interface vbm_out_if;
  import vbm_pkg::*;
  logic              valid;
  logic              ready;
  logic [MVAL_W-1:0] mask_value;

  modport source (output valid, mask_value, input ready);
  modport sink   (input valid, mask_value, output ready);
endinterface

`default_nettype wire

>>> src/vbm_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> src/vbm_sqrt_cell.sv
// One cell of the integer square root chain: retires one root bit per cycle
// and hands radicand, remainder, partial root and tag to the next cell.
`timescale 1ns / 1ps
`default_nettype none

module vbm_sqrt_cell #(
  parameter int DW = 20,
  parameter int TW = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            vld_i,
  input  logic [TW-1:0]   tag_i,
  input  logic [2*DW-1:0] rad_i,
  input  logic [DW+1:0]   rem_i,
  input  logic [DW-1:0]   root_i,
  output logic            vld_o,
  output logic [TW-1:0]   tag_o,
  output logic [2*DW-1:0] rad_o,
  output logic [DW+1:0]   rem_o,
  output logic [DW-1:0]   root_o
);

  logic            vld_r;
  logic [TW-1:0]   tag_r;
  logic [2*DW-1:0] rad_r,  rad_nxt;
  logic [DW+1:0]   rem_r,  rem_nxt;
  logic [DW-1:0]   root_r, root_nxt;
  logic [DW+1:0]   rem_sh, trial;
  logic            ge;

  // remainder stays below 2^DW until the last bit, so the top bits drop safely
  always_comb begin
    rem_sh   = {rem_i[DW-1:0], rad_i[2*DW-1 -: 2]};
    trial    = {root_i, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_i[DW-2:0], ge};
    rad_nxt  = {rad_i[2*DW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_i;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign vld_o  = vld_r;
  assign tag_o  = tag_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

`default_nettype wire

>>> src/voronoi_blend_mask_pixel_top.sv
// Load item: writes the tile table. Pixel item: each of the n active tiles (at least 1) is read
// from the table RAM, one tile read per cycle, then passes the tile pipeline and FRAC_BITS+16
// root cells; a margin compare follows unless a lone tile covers the pixel, then the ramp
// divider when the gap lies inside the margin band. An excluded own tile skips to the result.
// One pixel is worked on at a time; the next item is taken while a result waits.
// Reset (sync, active low) clears control and config; the tile table is undefined.
`timescale 1ns / 1ps
`default_nettype none

module voronoi_blend_mask_pixel_top #(
  parameter int MAX_TILES = 16,
  parameter int FRAC_BITS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  vbm_in_if.sink                          in_ch,
  vbm_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [vbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vbm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import vbm_pkg::*;

  localparam int IW   = $clog2(MAX_TILES);
  localparam int CNTW = $clog2(MAX_TILES + 1);
  localparam int DW   = FRAC_BITS + 16;
  localparam int RW   = 2 * DW;
  localparam int TW   = IW + 2;
  localparam int SW   = ((DW > 22) ? DW : 22) + 2;
  localparam int NUMW = 30;
  localparam int DENW = 22;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_OWN   = 8'b0000_0010,
    S_ISSUE = 8'b0000_0100,
    S_DRAIN = 8'b0000_1000,
    S_FIN   = 8'b0001_0000,
    S_CMP   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_RES   = 8'b1000_0000
  } state_t;

  state_t state_r;

  // configuration
  logic [MARGIN_W-1:0] margin_r;
  logic [TCOUNT_W-1:0] tcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= '0;
      tcount_r <= TCOUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MARGIN:     margin_r <= cfg_data[MARGIN_W-1:0];
        CFG_TILE_COUNT: tcount_r <= cfg_data[TCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNTW-1:0] count_c, n_issue;
  assign count_c = (32'(tcount_r) > 32'(MAX_TILES)) ? CNTW'(MAX_TILES) : CNTW'(tcount_r);
  assign n_issue = (count_c == '0) ? CNTW'(1) : count_c;

  // input side
  logic       in_acc, ti_ok;
  logic [6:0] ti7;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign ti7         = 7'(in_ch.tile_index);
  assign ti_ok       = (ti7 < 7'(MAX_TILES));

  // tile table
  logic [IW-1:0]         ram_raddr;
  logic [TILE_REC_W-1:0] ram_rdata;
  logic [CNTW-1:0]       ic_r;
  tile_rec_t             wr_rec, rd_rec;

  assign wr_rec    = '{ox: in_ch.origin_x, oy: in_ch.origin_y,
                       w: in_ch.tile_width, h: in_ch.tile_height};
  assign ram_raddr = (state_r == S_ISSUE) ? ic_r[IW-1:0] : ti7[IW-1:0];
  assign rd_rec    = tile_rec_t'(ram_rdata);

  vbm_ram #(.WIDTH(TILE_REC_W), .DEPTH(MAX_TILES)) u_table (
    .clk   (clk),
    .we    (in_acc && (in_ch.func == FUNC_LOAD) && ti_ok),
    .waddr (ti7[IW-1:0]),
    .wdata (wr_rec),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // pixel context
  logic [TIDX_W-1:0]   ti_r;
  logic                ti_ok_r;
  logic [PIX_W-1:0]    px_r, py_r;
  logic [MTILES_W-1:0] masked_r;
  logic signed [20:0]  cx_r, cy_r;
  logic [MVAL_W-1:0]   res_r;
  logic signed [SW-1:0] s_r;
  logic [NUMW-1:0]     rem_r;
  logic [DENW-1:0]     den_r;
  logic [2:0]          k_r;

  // tracker
  logic          have1_r, have2_r, fin_r;
  logic [DW-1:0] d1_r, d2_r;
  logic [IW-1:0] near_r;

  // finishing arithmetic
  logic                 closest;
  logic [DW-1:0]        diff;
  logic signed [SW-1:0] diff_s, m2s, sm;
  logic [21:0]          sm22;
  logic [NUMW-1:0]      dsh;
  logic                 out_free;
  logic signed [COORD_W-1:0] own_x, own_y;

  always_comb begin
    closest = have1_r && (7'(near_r) == 7'(ti_r));
    diff    = (have1_r && have2_r) ? (d2_r - d1_r) : '0;
    diff_s  = $signed(SW'(diff));
    m2s     = $signed(SW'({margin_r, 1'b0}));
    sm      = s_r + m2s;
    sm22    = sm[21:0];
    dsh     = NUMW'(den_r) << k_r;
    own_x   = ti_ok_r ? rd_rec.ox : '0;
    own_y   = ti_ok_r ? rd_rec.oy : '0;
  end

  assign out_free = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ic_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_ch.func == FUNC_PIXEL)) begin
            state_r <= in_ch.masked_tiles[in_ch.tile_index] ? S_RES : S_OWN;
          end
        end
        S_OWN: begin
          ic_r    <= '0;
          state_r <= S_ISSUE;
        end
        S_ISSUE: begin
          ic_r <= CNTW'(ic_r + 1'b1);
          if (CNTW'(ic_r + 1'b1) == n_issue) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: if (fin_r) state_r <= S_FIN;
        S_FIN: state_r <= (have1_r && !have2_r) ? S_RES : S_CMP;
        S_CMP: state_r <= ((s_r < -m2s) || (s_r >= m2s)) ? S_RES : S_DIV;
        S_DIV: if (k_r == 3'd0) state_r <= S_RES;
        S_RES: if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        ti_r     <= in_ch.tile_index;
        ti_ok_r  <= ti_ok;
        px_r     <= in_ch.pixel_x;
        py_r     <= in_ch.pixel_y;
        masked_r <= in_ch.masked_tiles;
        res_r    <= '0;
      end
      S_OWN: begin
        cx_r <= $signed({own_x[COORD_W-1], own_x}) + $signed({5'b0, px_r});
        cy_r <= $signed({own_y[COORD_W-1], own_y}) + $signed({5'b0, py_r});
      end
      S_FIN: begin
        res_r <= closest ? MVAL_MAX : '0;
        s_r   <= closest ? diff_s : -diff_s;
      end
      S_CMP: begin
        res_r <= (s_r < -m2s) ? '0 : MVAL_MAX;
        rem_r <= NUMW'({sm22, 8'b0}) - NUMW'(sm22);   // times 255
        den_r <= {margin_r, 2'b00};
        k_r   <= 3'd7;
      end
      S_DIV: begin
        if (rem_r >= dsh) begin
          rem_r      <= rem_r - dsh;
          res_r[k_r] <= 1'b1;
        end else begin
          res_r[k_r] <= 1'b0;
        end
        k_r <= k_r - 3'd1;
      end
      default: ;
    endcase
  end

  // per tile pipeline: issue, rectangle test, fold to center offset, square, sum
  logic                t0_vld_r, t0_last_r, t0_en_r;
  logic [IW-1:0]       t0_idx_r;
  logic                a_vld_r, a_last_r, a_en_r, a_msk_r;
  logic [IW-1:0]       a_idx_r;
  logic signed [21:0]  a_lx_r, a_ly_r;
  logic [SIZE_W-1:0]   a_w_r, a_h_r;
  logic                b_vld_r, b_last_r, b_use_r;
  logic [IW-1:0]       b_idx_r;
  logic [15:0]         b_ex_r, b_ey_r;
  logic                c_vld_r, c_last_r, c_use_r;
  logic [IW-1:0]       c_idx_r;
  logic [31:0]         c_sqx_r, c_sqy_r;
  logic [6:0]          t0_idx7;
  logic [17:0]         tx, ty, txn, tyn;
  logic                cov;
  logic [32:0]         sum_c;

  assign t0_idx7 = 7'(t0_idx_r);

  always_comb begin
    tx    = {a_lx_r[16:0], 1'b0} - {2'b0, a_w_r};
    ty    = {a_ly_r[16:0], 1'b0} - {2'b0, a_h_r};
    txn   = -tx;
    tyn   = -ty;
    cov   = !a_lx_r[21] && (a_lx_r[20:0] < {5'b0, a_w_r}) &&
            !a_ly_r[21] && (a_ly_r[20:0] < {5'b0, a_h_r});
    sum_c = {1'b0, c_sqx_r} + {1'b0, c_sqy_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_vld_r <= 1'b0;
      a_vld_r  <= 1'b0;
      b_vld_r  <= 1'b0;
      c_vld_r  <= 1'b0;
    end else begin
      t0_vld_r <= (state_r == S_ISSUE);
      a_vld_r  <= t0_vld_r;
      b_vld_r  <= a_vld_r;
      c_vld_r  <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    t0_last_r <= (CNTW'(ic_r + 1'b1) == n_issue);
    t0_en_r   <= (count_c != '0);
    t0_idx_r  <= ic_r[IW-1:0];

    a_last_r <= t0_last_r;
    a_en_r   <= t0_en_r;
    a_idx_r  <= t0_idx_r;
    a_msk_r  <= (t0_idx7 < 7'd16) && masked_r[t0_idx7[3:0]];
    a_lx_r   <= $signed({cx_r[20], cx_r}) - $signed({{2{rd_rec.ox[COORD_W-1]}}, rd_rec.ox});
    a_ly_r   <= $signed({cy_r[20], cy_r}) - $signed({{2{rd_rec.oy[COORD_W-1]}}, rd_rec.oy});
    a_w_r    <= rd_rec.w;
    a_h_r    <= rd_rec.h;

    b_last_r <= a_last_r;
    b_idx_r  <= a_idx_r;
    b_use_r  <= a_en_r && cov && !a_msk_r;
    b_ex_r   <= tx[17] ? txn[15:0] : tx[15:0];
    b_ey_r   <= ty[17] ? tyn[15:0] : ty[15:0];

    c_last_r <= b_last_r;
    c_idx_r  <= b_idx_r;
    c_use_r  <= b_use_r;
    c_sqx_r  <= b_ex_r * b_ex_r;
    c_sqy_r  <= b_ey_r * b_ey_r;
  end

  // square root chain, entry registered here
  logic          cv   [DW+1];
  logic [TW-1:0] ctag [DW+1];
  logic [RW-1:0] crad [DW+1];
  logic [DW+1:0] crem [DW+1];
  logic [DW-1:0] croot[DW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    ctag[0]  <= {c_use_r, c_last_r, c_idx_r};
    crad[0]  <= RW'(sum_c) << (2 * FRAC_BITS - 2);
    crem[0]  <= '0;
    croot[0] <= '0;
  end

  for (genvar k = 0; k < DW; k++) begin : g_cell
    vbm_sqrt_cell #(.DW(DW), .TW(TW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (cv[k]),
      .tag_i  (ctag[k]),
      .rad_i  (crad[k]),
      .rem_i  (crem[k]),
      .root_i (croot[k]),
      .vld_o  (cv[k+1]),
      .tag_o  (ctag[k+1]),
      .rad_o  (crad[k+1]),
      .rem_o  (crem[k+1]),
      .root_o (croot[k+1])
    );
  end

  // nearest / second nearest, ties keep the earlier tile
  logic          e_use, e_last;
  logic [IW-1:0] e_idx;
  logic [DW-1:0] e_d;
  assign {e_use, e_last, e_idx} = ctag[DW];
  assign e_d = croot[DW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have1_r <= 1'b0;
      have2_r <= 1'b0;
      fin_r   <= 1'b0;
    end else begin
      fin_r <= cv[DW] && e_last;
      if (state_r == S_OWN) begin
        have1_r <= 1'b0;
        have2_r <= 1'b0;
      end else if (cv[DW] && e_use) begin
        if (!have1_r || (e_d < d1_r)) begin
          have1_r <= 1'b1;
          if (have1_r) have2_r <= 1'b1;
        end else if (!have2_r || (e_d < d2_r)) begin
          have2_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cv[DW] && e_use) begin
      if (!have1_r || (e_d < d1_r)) begin
        d2_r   <= d1_r;
        d1_r   <= e_d;
        near_r <= e_idx;
      end else if (!have2_r || (e_d < d2_r)) begin
        d2_r <= e_d;
      end
    end
  end

  // result register
  logic              out_valid_r;
  logic [MVAL_W-1:0] out_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_RES) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_RES) && out_free) begin
      out_val_r <= res_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.mask_value = out_val_r;

endmodule

`default_nettype wire

>>> src/vbm_checker.sv
// Port-level checker for voronoi_blend_mask_pixel_top, attached by bind.
// Depends on vbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vbm_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        in_func,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [vbm_pkg::MVAL_W-1:0]  out_mask
);
  import vbm_pkg::*;

  // a pixel transfer blocks the input until its result is formed
  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_func == FUNC_PIXEL)) |=> !in_ready)
    else $error("input ready right after pixel transfer");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_func == FUNC_LOAD)) |=> in_ready)
    else $error("load transfer left block busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_mask)))
    else $error("stalled result changed");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without pending pixel");

endmodule

bind voronoi_blend_mask_pixel_top vbm_checker u_vbm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_func   (in_ch.func),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_mask  (out_ch.mask_value)
);

`default_nettype wire
